// File: src/cevq_pkg.sv
// Shared types and status codes for the coalescing event queue.
package cevq_pkg;

  // Result status codes.
  localparam logic [2:0] ST_QUEUED    = 3'd0;
  localparam logic [2:0] ST_COALESCED = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_POPPED    = 3'd3;
  localparam logic [2:0] ST_EMPTY     = 3'd4;

  // Operation codes carried in the mode field.
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // Fixed field widths of the channels.
  localparam int SRC_FIELD_W  = 8;
  localparam int BITS_FIELD_W = 32;
  localparam int USER_FIELD_W = 64;
  localparam int CFG_W        = 7;

  // One input beat.
  typedef struct packed {
    logic                    mode;
    logic [SRC_FIELD_W-1:0]  source_index;
    logic [BITS_FIELD_W-1:0] event_bits;
    logic [USER_FIELD_W-1:0] user_word;
  } cevq_in_t;

  // One result beat.
  typedef struct packed {
    logic [2:0]              status;
    logic [SRC_FIELD_W-1:0]  out_source_index;
    logic [BITS_FIELD_W-1:0] out_event_bits;
    logic [USER_FIELD_W-1:0] out_user_word;
  } cevq_out_t;

endpackage

// File: src/cevq_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module cevq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; data holds while re is low.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/coalescing_event_queue.sv
// Coalescing event queue: a ring of events with per-source pending-bit coalescing.
//
// A push keeps only the event bits not already pending for its source; if any
// remain it marks them pending and appends (source, new bits, user word) to the
// ring, otherwise it reports "coalesced". A pop returns the oldest entry and
// clears its bits from that source's pending mask. Full and empty are reported
// as status and change nothing. The queue entries and the per-source pending
// masks live in two single-read-port RAMs with registered reads. One item is
// worked on at a time: a push reads the pending mask, then updates it and
// writes it back; a pop reads the entry, then the pending mask of that entry's
// source, then writes back, or reports empty after the entry read when the
// queue is empty, so the rate is set by these dependent RAM reads. A result
// waits in the output register while the next item is accepted; the final
// write-back stalls only when that register is still occupied. After reset the
// block clears the pending-mask RAM, one source per cycle, and accepts no item
// until that is done. Writes to the capacity register are taken at any time.
module coalescing_event_queue #(
  parameter int QUEUE_DEPTH  = 64,
  parameter int SOURCE_COUNT = 256,
  parameter int EVENT_WIDTH  = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  cevq_pkg::cevq_in_t        in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output cevq_pkg::cevq_out_t       out_data,
  input  logic                      cfg_we,
  input  logic [cevq_pkg::CFG_W-1:0] cfg_wdata
);

  import cevq_pkg::*;

  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int SRC_AW = $clog2(SOURCE_COUNT);
  localparam int CMP_W  = (PTR_W + 1 > CFG_W) ? PTR_W + 1 : CFG_W;
  localparam int ENT_W  = SRC_FIELD_W + EVENT_WIDTH + USER_FIELD_W;
  localparam int SRC_SPAN = 1 << SRC_FIELD_W;

  // Sequencer states.
  localparam logic [2:0] S_CLEAR    = 3'd0;
  localparam logic [2:0] S_IDLE     = 3'd1;
  localparam logic [2:0] S_PUSH_EX  = 3'd2;
  localparam logic [2:0] S_POP_LOOK = 3'd3;
  localparam logic [2:0] S_POP_EX   = 3'd4;

  logic [2:0]             state_r, state_nxt;
  logic [SRC_AW-1:0]      clr_cnt_r, clr_cnt_nxt;
  logic [PTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [CNT_W-1:0]       fill_r, fill_nxt;
  logic [CNT_W-1:0]       cap_r, cap_nxt;
  logic                   out_valid_r, out_valid_nxt;
  cevq_out_t              out_r, out_nxt;

  // Latched push operands (payload, no reset).
  logic [SRC_AW-1:0]      op_src_r;
  logic [EVENT_WIDTH-1:0] op_bits_r;
  logic [USER_FIELD_W-1:0] op_user_r;

  // Source index modulo SOURCE_COUNT as a constant table.
  logic [SRC_AW-1:0]      src_tbl [SRC_SPAN];
  for (genvar g = 0; g < SRC_SPAN; g++) begin : g_src_tbl
    assign src_tbl[g] = SRC_AW'(g % SOURCE_COUNT);
  end

  // RAM ports.
  logic                   ent_we, ent_re;
  logic [ENT_W-1:0]       ent_wdata, ent_rdata;
  logic                   pnd_we, pnd_re;
  logic [SRC_AW-1:0]      pnd_waddr, pnd_raddr;
  logic [EVENT_WIDTH-1:0] pnd_wdata, pnd_rdata;

  cevq_ram #(.WIDTH(ENT_W), .DEPTH(QUEUE_DEPTH)) u_entry_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (wr_ptr_r),
    .wdata (ent_wdata),
    .re    (ent_re),
    .raddr (rd_ptr_r),
    .rdata (ent_rdata)
  );

  cevq_ram #(.WIDTH(EVENT_WIDTH), .DEPTH(SOURCE_COUNT)) u_pending_ram (
    .clk   (clk),
    .we    (pnd_we),
    .waddr (pnd_waddr),
    .wdata (pnd_wdata),
    .re    (pnd_re),
    .raddr (pnd_raddr),
    .rdata (pnd_rdata)
  );

  // Fields of the entry being popped.
  logic [SRC_FIELD_W-1:0]  ent_src;
  logic [EVENT_WIDTH-1:0]  ent_bits;
  logic [USER_FIELD_W-1:0] ent_user;
  logic [SRC_AW-1:0]       ent_src_mod;

  assign ent_user    = ent_rdata[USER_FIELD_W-1:0];
  assign ent_bits    = ent_rdata[USER_FIELD_W +: EVENT_WIDTH];
  assign ent_src     = ent_rdata[ENT_W-1 -: SRC_FIELD_W];
  assign ent_src_mod = src_tbl[ent_src];

  logic                   in_fire, out_free, full, load;
  logic [EVENT_WIDTH-1:0] fresh;
  logic [CMP_W-1:0]       wr_inc, rd_inc;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign fresh  = op_bits_r & ~pnd_rdata;
  assign full   = CMP_W'(fill_r) >= CMP_W'(cap_r);
  assign wr_inc = CMP_W'(wr_ptr_r) + CMP_W'(1);
  assign rd_inc = CMP_W'(rd_ptr_r) + CMP_W'(1);

  // An entry holds only the bits that this push made pending.
  assign ent_wdata = {8'(op_src_r), fresh, op_user_r};

  // Capacity register, clamped to 1..QUEUE_DEPTH when written.
  always_comb begin
    cap_nxt = cap_r;
    if (cfg_we) begin
      if (cfg_wdata == '0) begin
        cap_nxt = CNT_W'(1);
      end else if (CMP_W'(cfg_wdata) > CMP_W'(QUEUE_DEPTH)) begin
        cap_nxt = CNT_W'(QUEUE_DEPTH);
      end else begin
        cap_nxt = CNT_W'(cfg_wdata);
      end
    end
  end

  // Sequencer: RAM reads, read-modify-write of the pending mask, result load.
  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    rd_ptr_nxt    = rd_ptr_r;
    wr_ptr_nxt    = wr_ptr_r;
    fill_nxt      = fill_r;
    out_nxt       = out_r;
    load          = 1'b0;
    ent_we        = 1'b0;
    ent_re        = 1'b0;
    pnd_we        = 1'b0;
    pnd_re        = 1'b0;
    pnd_waddr     = op_src_r;
    pnd_wdata     = pnd_rdata | fresh;
    pnd_raddr     = src_tbl[in_data.source_index];

    case (state_r)
      S_CLEAR: begin
        pnd_we    = 1'b1;
        pnd_waddr = clr_cnt_r;
        pnd_wdata = '0;
        clr_cnt_nxt = clr_cnt_r + SRC_AW'(1);
        if (clr_cnt_r == SRC_AW'(SOURCE_COUNT - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          if (in_data.mode == OP_PUSH) begin
            pnd_re    = 1'b1;
            state_nxt = S_PUSH_EX;
          end else begin
            ent_re    = 1'b1;
            state_nxt = S_POP_LOOK;
          end
        end
      end
      S_PUSH_EX: begin
        if (out_free) begin
          load      = 1'b1;
          state_nxt = S_IDLE;
          out_nxt   = '0;
          if (fresh == '0) begin
            out_nxt.status = ST_COALESCED;
          end else if (full) begin
            out_nxt.status = ST_FULL;
          end else begin
            out_nxt.status         = ST_QUEUED;
            out_nxt.out_event_bits = BITS_FIELD_W'(fresh);
            pnd_we   = 1'b1;
            ent_we   = 1'b1;
            fill_nxt = fill_r + CNT_W'(1);
            wr_ptr_nxt = (wr_inc >= CMP_W'(cap_r)) ? '0 : PTR_W'(wr_inc);
          end
        end
      end
      S_POP_LOOK: begin
        if (fill_r == '0) begin
          if (out_free) begin
            load           = 1'b1;
            out_nxt        = '0;
            out_nxt.status = ST_EMPTY;
            state_nxt      = S_IDLE;
          end
        end else begin
          pnd_re    = 1'b1;
          pnd_raddr = ent_src_mod;
          state_nxt = S_POP_EX;
        end
      end
      S_POP_EX: begin
        if (out_free) begin
          load      = 1'b1;
          state_nxt = S_IDLE;
          out_nxt.status           = ST_POPPED;
          out_nxt.out_source_index = ent_src;
          out_nxt.out_event_bits   = BITS_FIELD_W'(ent_bits);
          out_nxt.out_user_word    = ent_user;
          pnd_we    = 1'b1;
          pnd_waddr = ent_src_mod;
          pnd_wdata = pnd_rdata & ~ent_bits;
          fill_nxt  = fill_r - CNT_W'(1);
          rd_ptr_nxt = (rd_inc >= CMP_W'(cap_r)) ? '0 : PTR_W'(rd_inc);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output register handshake.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (load) begin
      out_valid_nxt = 1'b1;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      rd_ptr_r    <= '0;
      wr_ptr_r    <= '0;
      fill_r      <= '0;
      cap_r       <= CNT_W'(QUEUE_DEPTH);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      fill_r      <= fill_nxt;
      cap_r       <= cap_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (in_fire) begin
      op_src_r  <= src_tbl[in_data.source_index];
      op_bits_r <= in_data.event_bits[EVENT_WIDTH-1:0];
      op_user_r <= in_data.user_word;
    end
  end

  // Fill level never exceeds the ring size.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(fill_r) <= CMP_W'(QUEUE_DEPTH))
    else $error("fill level above queue depth");

  // An empty report is only given when nothing is queued.
  a_empty_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (load && out_nxt.status == ST_EMPTY) |-> fill_r == '0)
    else $error("empty reported with entries queued");

  // A queued push raises the fill level by one.
  a_push_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (load && out_nxt.status == ST_QUEUED) |=> fill_r == $past(fill_r) + CNT_W'(1))
    else $error("queued push did not advance fill level");

  // A pop lowers the fill level by one.
  a_pop_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (load && out_nxt.status == ST_POPPED) |=> fill_r == $past(fill_r) - CNT_W'(1))
    else $error("pop did not lower fill level");

  // A pending-mask read and write never coincide, so no forwarding is needed.
  a_pnd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(pnd_we && pnd_re))
    else $error("pending mask read and write overlap");

endmodule

// File: verif/tb.sv
// Self-checking testbench for the coalescing event queue.
`timescale 1ns / 1ps

module tb;
  import cevq_pkg::*;

  localparam int RING_DEPTH       = 64;
  localparam int SOURCE_TOTAL     = 256;
  localparam int MAX_IDLE         = 13;
  localparam int WATCHDOG_LIMIT   = 2000;
  localparam int TAIL_CYCLES      = 8;
  localparam int PHASE_COUNT      = 12;
  localparam int ITEMS_PER_PHASE  = 100;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  cevq_in_t             in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  cevq_out_t            out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  // Shadow copy of the queue state, advanced as each beat is accepted.
  logic [BITS_FIELD_W-1:0] ring_bits [RING_DEPTH];
  logic [SRC_FIELD_W-1:0]  ring_src  [RING_DEPTH];
  logic [USER_FIELD_W-1:0] ring_user [RING_DEPTH];
  logic [BITS_FIELD_W-1:0] src_pending [SOURCE_TOTAL] = '{default: '0};
  int                      head_ptr = 0;
  int                      tail_ptr = 0;
  int                      ring_fill = 0;
  logic [CFG_W-1:0]        capacity_reg = 7'd64;

  cevq_out_t awaited_results [$];
  cevq_out_t want_beat;
  int        fault_count = 0;
  int        idle_cycles = 0;
  bit        idle_on = 1'b0;

  coalescing_event_queue dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Capacity as the block uses it: zero acts as one, anything above the ring depth clamps.
  function automatic int usable_slots();
    int c;
    c = capacity_reg;
    if (c < 1) c = 1;
    if (c > RING_DEPTH) c = RING_DEPTH;
    return c;
  endfunction

  function automatic int next_slot(int p);
    return (p + 1 >= usable_slots()) ? 0 : p + 1;
  endfunction

  // Works out the result of one queue operation and updates the shadow state.
  function automatic cevq_out_t queue_op_result(cevq_in_t beat);
    cevq_out_t               res;
    logic [BITS_FIELD_W-1:0] fresh;
    int                      slot;
    res = '0;
    if (beat.mode == OP_PUSH) begin
      fresh = beat.event_bits & ~src_pending[beat.source_index];
      if (fresh == '0) begin
        res.status = ST_COALESCED;
      end else if (ring_fill >= usable_slots()) begin
        res.status = ST_FULL;
      end else begin
        slot = tail_ptr;
        src_pending[beat.source_index] |= fresh;
        ring_bits[slot] = fresh;
        ring_src[slot]  = beat.source_index;
        ring_user[slot] = beat.user_word;
        tail_ptr = next_slot(slot);
        ring_fill++;
        res.status = ST_QUEUED;
        res.out_event_bits = fresh;
      end
    end else if (ring_fill == 0) begin
      res.status = ST_EMPTY;
    end else begin
      slot = head_ptr;
      src_pending[ring_src[slot]] &= ~ring_bits[slot];
      res.status           = ST_POPPED;
      res.out_source_index = ring_src[slot];
      res.out_event_bits   = ring_bits[slot];
      res.out_user_word    = ring_user[slot];
      head_ptr = next_slot(slot);
      ring_fill--;
    end
    return res;
  endfunction

  function automatic cevq_in_t random_beat(int push_pct, bit wide_sources);
    cevq_in_t beat;
    beat.mode = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
    beat.source_index = (wide_sources || $urandom_range(0, 4) == 0) ?
                        8'($urandom) : 8'($urandom_range(0, 7));
    case ($urandom_range(0, 5))
      0: beat.event_bits = 32'd1 << $urandom_range(0, 31);
      1: beat.event_bits = $urandom & $urandom & $urandom;
      2: beat.event_bits = '1;
      3: beat.event_bits = '0;
      default: beat.event_bits = $urandom;
    endcase
    beat.user_word = {$urandom, $urandom};
    return beat;
  endfunction

  function automatic cevq_in_t push_beat(logic [7:0] src, logic [31:0] bits, logic [63:0] user);
    cevq_in_t beat;
    beat.mode         = OP_PUSH;
    beat.source_index = src;
    beat.event_bits   = bits;
    beat.user_word    = user;
    return beat;
  endfunction

  // Sends one beat, after a random gap when idle_on is set, and records its expected result on acceptance.
  // Valid is left high afterward so back-to-back beats never drop it.
  task automatic send_beat(cevq_in_t beat);
    int gap;
    gap = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (in_ready !== 1'b1);
    awaited_results.push_back(queue_op_result(beat));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  // Empties the ring first so a smaller capacity never exposes unwritten entries.
  task automatic write_capacity(logic [CFG_W-1:0] value);
    while (ring_fill != 0) send_beat(random_beat(0, 1'b1));
    wait_drained();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we       <= 1'b0;
    capacity_reg = value;
  endtask

  // Empty pops, pushes with nothing new, and coalescing against pending bits.
  task automatic test_empty_and_coalescing();
    idle_on = 1'b0;
    send_beat(random_beat(0, 1'b1));
    send_beat(push_beat(8'd0, 32'h0, 64'h0));
    send_beat(push_beat(8'd255, 32'hffff_ffff, 64'hffff_ffff_ffff_ffff));
    send_beat(push_beat(8'd255, 32'hffff_ffff, 64'h5a5a_5a5a_5a5a_5a5a));
    send_beat(push_beat(8'd0, 32'h0000_00ff, 64'h0123_4567_89ab_cdef));
    send_beat(push_beat(8'd0, 32'h0000_0f0f, 64'hfedc_ba98_7654_3210));
    send_beat(random_beat(0, 1'b1));
    send_beat(push_beat(8'd255, 32'h8000_0001, 64'h8000_0000_0000_0001));
    repeat (4) send_beat(random_beat(0, 1'b1));
  endtask

  // Full queue at the smallest capacities, and pointer wraparound.
  task automatic test_capacity_limits();
    idle_on = 1'b1;
    write_capacity(7'd1);
    send_beat(push_beat(8'd1, 32'h1, 64'h11));
    send_beat(push_beat(8'd2, 32'h1, 64'h22));
    // A push with nothing new coalesces even while the queue is full.
    send_beat(push_beat(8'd1, 32'h1, 64'h33));
    send_beat(push_beat(8'd1, 32'h3, 64'h44));
    send_beat(random_beat(0, 1'b1));
    send_beat(random_beat(0, 1'b1));
    // The rejected push above must not have left source 2 pending.
    send_beat(push_beat(8'd2, 32'h1, 64'h55));
    write_capacity(7'd0);
    send_beat(push_beat(8'd3, 32'h8000_0000, 64'h66));
    send_beat(push_beat(8'd4, 32'h1, 64'h77));
    write_capacity(7'd2);
    send_beat(push_beat(8'd5, 32'h1, 64'h88));
    send_beat(push_beat(8'd6, 32'h2, 64'h99));
    send_beat(push_beat(8'd7, 32'h4, 64'haa));
    send_beat(random_beat(0, 1'b1));
    send_beat(push_beat(8'd7, 32'h4, 64'hbb));
    repeat (3) send_beat(random_beat(0, 1'b1));
  endtask

  // Random traffic over a range of capacities, with the push share varied per phase.
  task automatic test_random_traffic();
    int unsigned phase_capacity [PHASE_COUNT] =
      '{64, 1, 127, 0, 3, 100, 2, 64, 7, 127, 33, 64};
    int unsigned phase_push_pct [PHASE_COUNT] =
      '{70, 55, 95, 50, 60, 90, 45, 65, 75, 85, 50, 40};
    int unsigned cap;
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      cap = (ph == 10) ? $urandom_range(0, 127) : phase_capacity[ph];
      write_capacity(CFG_W'(cap));
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n % 25 == 0) idle_on = ($urandom_range(0, 3) != 0);
        // In even phases, hold the sender halfway until every result is back.
        if (n == ITEMS_PER_PHASE / 2 && ph % 2 == 0) wait_drained();
        send_beat(random_beat(phase_push_pct[ph], phase_push_pct[ph] >= 85));
      end
    end
  endtask

  task automatic compare_field(string field, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h, actual %0h", $time, field, want, got);
      fault_count++;
    end
  endtask

  // Result side: a random stall before each beat when idle_on is set, then ready until one is taken.
  initial begin
    int stall;
    forever begin
      stall = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  // Compare each result beat with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, out_data);
        fault_count++;
      end else begin
        want_beat = awaited_results.pop_front();
        compare_field("status", 64'(want_beat.status), 64'(out_data.status));
        compare_field("out_source_index", 64'(want_beat.out_source_index),
                      64'(out_data.out_source_index));
        compare_field("out_event_bits", 64'(want_beat.out_event_bits),
                      64'(out_data.out_event_bits));
        compare_field("out_user_word", want_beat.out_user_word, out_data.out_user_word);
      end
    end
  end

  // Watchdog on cycles in which neither channel moves a beat.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Test sequence.
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_and_coalescing();
    test_capacity_limits();
    test_random_traffic();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fault_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
